>>> rtl/core/ifps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifps_pkg: shared types and constants of the iterated five-point stencil
// Payload structs, weight set, cell transaction type and arithmetic widths.
// ----------------------------------------------------------------------------
package ifps_pkg;

  localparam int SAMPLE_W   = 32;  // Q16.16 grid value
  localparam int WEIGHT_W   = 16;  // Q2.14 stencil weight
  localparam int FRAC_SHIFT = 14;  // product Q18.30 -> Q16.16
  localparam int RC_W       = 7;   // row / column field width on the result port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = WEIGHT_W;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 16'sd4096;  // 0.25
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_UP     = 3'd0,
    CFG_WEIGHT_LEFT   = 3'd1,
    CFG_WEIGHT_CENTRE = 3'd2,
    CFG_WEIGHT_RIGHT  = 3'd3,
    CFG_WEIGHT_DOWN   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       tile_start;
  } in_payload_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result_value;
    logic [RC_W-1:0]            result_row;
    logic [RC_W-1:0]            result_col;
    logic                       result_last;
  } out_payload_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] up;
    logic signed [WEIGHT_W-1:0] left;
    logic signed [WEIGHT_W-1:0] centre;
    logic signed [WEIGHT_W-1:0] right;
    logic signed [WEIGHT_W-1:0] down;
  } weights_t;

  // one sample slot travelling down the chain
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
  } token_t;

endpackage
`default_nettype wire

>>> rtl/core/ifps_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifps_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held while idle.
// ----------------------------------------------------------------------------
module ifps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ifps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifps_cell: one stencil pass
// Keeps the last two lines it received in a line RAM (one entry per column,
// newer and older row side by side), forms the five-point window and emits
// the weighted, saturated sum one row up via its window, product and sum stages.
// ----------------------------------------------------------------------------
module ifps_cell
  import ifps_pkg::*;
#(
  parameter int GRID_N = 128,
  localparam int POS_W = $clog2(GRID_N)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire weights_t           weights,
  input  wire token_t             in_tok,
  input  wire logic [2*POS_W-1:0] in_pos,
  output token_t                  out_tok,
  output logic      [2*POS_W-1:0] out_pos
);

  localparam int LINE_W = 2 * SAMPLE_W;
  localparam int PROD_W = SAMPLE_W + WEIGHT_W;
  localparam int TERM_W = PROD_W - FRAC_SHIFT;
  localparam int SUM_W  = TERM_W + 3;

  logic [POS_W-1:0]           col;
  logic [POS_W-1:0]           col_next;
  logic                       fire;
  logic [LINE_W-1:0]          rd_line;
  logic signed [SAMPLE_W-1:0] rd_new;
  logic signed [SAMPLE_W-1:0] rd_old;

  assign col      = in_pos[POS_W-1:0];
  assign col_next = (col == POS_W'(GRID_N - 1)) ? '0 : col + 1'b1;
  assign fire     = advance && in_tok.valid;
  assign rd_new   = rd_line[LINE_W-1:SAMPLE_W];
  assign rd_old   = rd_line[SAMPLE_W-1:0];

  // read ahead one column: the data returned now is this sample's right
  // neighbor and the next sample's centre and up
  ifps_ram #(
    .WIDTH (LINE_W),
    .DEPTH (GRID_N)
  ) u_line (
    .clk   (clk),
    .we    (fire),
    .waddr (col),
    .wdata ({in_tok.value, rd_new}),
    .re    (fire),
    .raddr (col_next),
    .rdata (rd_line)
  );

  // window stage
  logic                       b_valid_r;
  logic [2*POS_W-1:0]         b_pos_r;
  logic signed [SAMPLE_W-1:0] b_up_r;
  logic signed [SAMPLE_W-1:0] b_left_r;
  logic signed [SAMPLE_W-1:0] b_centre_r;
  logic signed [SAMPLE_W-1:0] b_down_r;
  logic signed [SAMPLE_W-1:0] left_hold_r;

  // product stage
  logic signed [PROD_W-1:0] p_up, p_left, p_centre, p_right, p_down;
  logic                     c_valid_r;
  logic [2*POS_W-1:0]       c_pos_r;
  logic signed [TERM_W-1:0] c_up_r, c_left_r, c_centre_r, c_right_r, c_down_r;

  // sum stage
  logic signed [SUM_W-1:0]    c_sum;
  logic signed [SAMPLE_W-1:0] c_sat;
  logic                       out_valid_r;
  logic [2*POS_W-1:0]         out_pos_r;
  logic signed [SAMPLE_W-1:0] out_value_r;

  assign p_up     = b_up_r * weights.up;
  assign p_left   = b_left_r * weights.left;
  assign p_centre = b_centre_r * weights.centre;
  assign p_right  = rd_new * weights.right;
  assign p_down   = b_down_r * weights.down;

  always_comb begin
    c_sum = SUM_W'(c_up_r) + SUM_W'(c_left_r) + SUM_W'(c_centre_r)
          + SUM_W'(c_right_r) + SUM_W'(c_down_r);
    if ((&c_sum[SUM_W-1:SAMPLE_W-1]) || !(|c_sum[SUM_W-1:SAMPLE_W-1])) begin
      c_sat = c_sum[SAMPLE_W-1:0];
    end else if (c_sum[SUM_W-1]) begin
      c_sat = SAT_MIN;
    end else begin
      c_sat = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r   <= in_tok.valid;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_pos_r     <= in_pos;
      b_up_r      <= rd_old;
      b_centre_r  <= rd_new;
      b_left_r    <= left_hold_r;
      b_down_r    <= in_tok.value;
      left_hold_r <= rd_new;
    end
    // drop the low fraction bits: arithmetic shift, rounds toward minus infinity
    if (advance && b_valid_r) begin
      c_pos_r    <= b_pos_r;
      c_up_r     <= p_up[PROD_W-1:FRAC_SHIFT];
      c_left_r   <= p_left[PROD_W-1:FRAC_SHIFT];
      c_centre_r <= p_centre[PROD_W-1:FRAC_SHIFT];
      c_right_r  <= p_right[PROD_W-1:FRAC_SHIFT];
      c_down_r   <= p_down[PROD_W-1:FRAC_SHIFT];
    end
    if (advance && c_valid_r) begin
      out_pos_r   <= c_pos_r;
      out_value_r <= c_sat;
    end
  end

  assign out_tok.valid = out_valid_r;
  assign out_tok.value = out_value_r;
  assign out_pos       = out_pos_r;

endmodule
`default_nettype wire

>>> rtl/core/iterated_five_point_stencil_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iterated_five_point_stencil_top: iterated weighted five-point stencil
// Chain of PASSES stencil cells over a raster stream of GRID_N x GRID_N tiles.
// ----------------------------------------------------------------------------
// Takes one Q16.16 sample per cycle in raster order, unless stalled, and runs
// it through PASSES identical cells, each applying the Q2.14 weighted
// five-point stencil once. A sample's result passes one input register, then
// three register stages in every cell (line RAM read, multiply, sum and
// saturate), then the output register. Each cell's line RAM is read and
// written once per sample, so the chain sustains one sample per cycle unless
// stalled. Only cells inside the final valid area (rows and columns PASSES
// .. GRID_N-1-PASSES) produce a result transaction, at most one per sample,
// in raster order. in_ready drops only while a finished result reaches the
// end of the chain and the output register still holds an untaken one. The
// line RAMs need no clearing after reset: entries not yet written by the
// current tile only feed cells outside the valid area. Weights are written
// through the cfg port while the block is idle, an unchecked user duty.
// ----------------------------------------------------------------------------
module iterated_five_point_stencil_top
  import ifps_pkg::*;
#(
  parameter int GRID_N = 128,
  parameter int PASSES = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_payload_t           in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_payload_t               out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int POS_W = $clog2(GRID_N);

  logic                       advance;
  logic                       in_accept;
  weights_t                   weights_r;

  logic [POS_W-1:0]           row_r, col_r;
  logic [POS_W-1:0]           cur_row, cur_col;
  logic [POS_W-1:0]           row_nxt, col_nxt;
  logic                       in_valid_r;
  logic signed [SAMPLE_W-1:0] in_value_r;
  logic [2*POS_W-1:0]         in_pos_r;

  token_t                     tok [PASSES+1];
  logic [2*POS_W-1:0]         pos [PASSES+1];

  logic [POS_W-1:0]           tail_row, tail_col;
  logic                       tail_hit, tail_last;
  logic                       out_valid_r;
  out_payload_t               out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r.up     <= WEIGHT_RESET;
      weights_r.left   <= WEIGHT_RESET;
      weights_r.centre <= WEIGHT_RESET;
      weights_r.right  <= WEIGHT_RESET;
      weights_r.down   <= WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WEIGHT_UP:     weights_r.up     <= cfg_wdata;
        CFG_WEIGHT_LEFT:   weights_r.left   <= cfg_wdata;
        CFG_WEIGHT_CENTRE: weights_r.centre <= cfg_wdata;
        CFG_WEIGHT_RIGHT:  weights_r.right  <= cfg_wdata;
        CFG_WEIGHT_DOWN:   weights_r.down   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // raster position of the accepted sample; tile_start restarts the tile
  always_comb begin
    cur_row = in_data.tile_start ? '0 : row_r;
    cur_col = in_data.tile_start ? '0 : col_r;
    row_nxt = cur_row;
    col_nxt = cur_col + 1'b1;
    if (cur_col == POS_W'(GRID_N - 1)) begin
      col_nxt = '0;
      row_nxt = (cur_row == POS_W'(GRID_N - 1)) ? '0 : cur_row + 1'b1;
    end
  end

  assign in_accept = in_valid && advance;
  assign in_ready  = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      in_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        in_valid_r <= in_valid;
      end
      if (in_accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_value_r <= in_data.sample;
      in_pos_r   <= {cur_row, cur_col};
    end
  end

  assign tok[0].valid = in_valid_r;
  assign tok[0].value = in_value_r;
  assign pos[0]       = in_pos_r;

  for (genvar i = 0; i < PASSES; i++) begin : g_cell
    ifps_cell #(
      .GRID_N (GRID_N)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .weights (weights_r),
      .in_tok  (tok[i]),
      .in_pos  (pos[i]),
      .out_tok (tok[i+1]),
      .out_pos (pos[i+1])
    );
  end

  // the tail carries the input position; its cell sits PASSES rows up
  assign tail_row  = pos[PASSES][2*POS_W-1:POS_W];
  assign tail_col  = pos[PASSES][POS_W-1:0];
  assign tail_hit  = tok[PASSES].valid
                  && (int'(tail_row) >= 2 * PASSES)
                  && (int'(tail_col) >= PASSES)
                  && (int'(tail_col) <= GRID_N - 1 - PASSES);
  assign tail_last = (int'(tail_row) == GRID_N - 1)
                  && (int'(tail_col) == GRID_N - 1 - PASSES);

  // hold the chain only when a result would overrun the waiting output
  assign advance = !(tail_hit && out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && tail_hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tail_hit) begin
      out_data_r.result_value <= tok[PASSES].value;
      out_data_r.result_row   <= RC_W'(int'(tail_row) - PASSES);
      out_data_r.result_col   <= RC_W'(tail_col);
      out_data_r.result_last  <= tail_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> tb/iterated_five_point_stencil_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterated_five_point_stencil_top_tb: self-checking bench of the stencil chain
// Streams raster tiles through the block under random handshake stalls and
// predicts every final-pass cell with its own chain of pass line stores.
// Each result transaction is checked in order against the predicted cells.
// The run covers reset and programmed weight sets, tile overrun and
// mid-tile restarts.
// ----------------------------------------------------------------------------
module iterated_five_point_stencil_top_tb;
  import ifps_pkg::*;

  localparam int GRID_N      = 128;
  localparam int PASSES      = 11;
  localparam int LAST_RC     = GRID_N - 1 - PASSES;
  localparam int LATENCY     = 3 * PASSES + 2;
  localparam int RESULT_ROWS = 2 * PASSES + 2;  // input rows that reach two result rows
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [WEIGHT_W-1:0] W_MAX  = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_MIN  = {1'b1, {(WEIGHT_W-1){1'b0}}};
  localparam logic signed [WEIGHT_W-1:0] W_ZERO = '0;
  localparam logic signed [WEIGHT_W-1:0] W_ONE  = WEIGHT_W'(1 << FRAC_SHIFT);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_payload_t           in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_payload_t          out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state: per pass two lines of the values that pass received
  logic signed [SAMPLE_W-1:0] stage_lines [PASSES*2*GRID_N];
  int                         next_row;
  int                         next_col;
  weights_t                   model_weights;

  out_payload_t expected_cells[$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  logic         idle_on     = 1'b0;
  int           stall_left  = 0;

  iterated_five_point_stencil_top #(
    .GRID_N(GRID_N),
    .PASSES(PASSES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Q16.16 sample times Q2.14 weight, floored back to Q16.16
  function automatic longint weighted(input logic signed [SAMPLE_W-1:0] a,
                                      input logic signed [WEIGHT_W-1:0] w);
    longint p;
    p = longint'(a) * longint'(w);
    return p >>> FRAC_SHIFT;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp32(input longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return SAMPLE_W'(v);
  endfunction

  function automatic bit predict_stencil_step(input in_payload_t item,
                                              output out_payload_t predicted);
    logic signed [SAMPLE_W-1:0] v;
    logic signed [SAMPLE_W-1:0] up;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    int r;
    int cur_base;
    int prev_base;
    longint acc;
    bit hit;
    hit       = 1'b0;
    predicted = '0;
    v         = item.sample;
    if (item.tile_start) begin
      next_row = 0;
      next_col = 0;
    end
    for (int p = 1; p <= PASSES; p++) begin
      r = next_row - (p - 1);
      // rows not yet reached by this pass leave it and all later passes alone
      if (r >= 0) begin
        cur_base  = ((p - 1) * 2 + (r % 2)) * GRID_N;
        prev_base = ((p - 1) * 2 + ((r + 1) % 2)) * GRID_N;
        up    = stage_lines[cur_base + next_col];
        left  = (next_col > 0) ? stage_lines[prev_base + next_col - 1] : '0;
        right = (next_col + 1 < GRID_N) ? stage_lines[prev_base + next_col + 1] : '0;
        acc = weighted(up, model_weights.up) + weighted(left, model_weights.left)
            + weighted(stage_lines[prev_base + next_col], model_weights.centre)
            + weighted(right, model_weights.right) + weighted(v, model_weights.down);
        stage_lines[cur_base + next_col] = v;
        v = clamp32(acc);
        if (p == PASSES && r - 1 >= PASSES && r - 1 <= LAST_RC
            && next_col >= PASSES && next_col <= LAST_RC) begin
          predicted.result_value = v;
          predicted.result_row   = RC_W'(r - 1);
          predicted.result_col   = RC_W'(next_col);
          predicted.result_last  = (r - 1 == LAST_RC) && (next_col == LAST_RC);
          hit = 1'b1;
        end
      end
    end
    next_col++;
    if (next_col >= GRID_N) begin
      next_col = 0;
      next_row++;
      if (next_row >= GRID_N) next_row = 0;
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_results
    out_payload_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %0d row %0d col %0d last %0b",
                   out_data.result_value, out_data.result_row,
                   out_data.result_col, out_data.result_last);
      end else begin
        want = expected_cells.pop_front();
        if (out_data.result_value !== want.result_value
            || out_data.result_row !== want.result_row
            || out_data.result_col !== want.result_col
            || out_data.result_last !== want.result_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch (exp/got): value %0d/%0d row %0d/%0d col %0d/%0d last %0b/%0b",
                     want.result_value, out_data.result_value,
                     want.result_row, out_data.result_row,
                     want.result_col, out_data.result_col,
                     want.result_last, out_data.result_last);
        end
      end
    end
  end

  // result side: drop out_ready in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int shift);
    case ($urandom_range(0, 15))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2:       return '0;
      default: return $signed($urandom) >>> shift;
    endcase
  endfunction

  function automatic weights_t random_weights(input bit gentle);
    weights_t w;
    w.up     = gentle ? WEIGHT_W'($urandom_range(3000, 5200)) : WEIGHT_W'($urandom);
    w.left   = gentle ? WEIGHT_W'($urandom_range(3000, 5200)) : WEIGHT_W'($urandom);
    w.centre = gentle ? WEIGHT_W'($urandom_range(3000, 5200)) : WEIGHT_W'($urandom);
    w.right  = gentle ? WEIGHT_W'($urandom_range(3000, 5200)) : WEIGHT_W'($urandom);
    w.down   = gentle ? WEIGHT_W'($urandom_range(3000, 5200)) : WEIGHT_W'($urandom);
    return w;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic ts);
    in_payload_t  item;
    out_payload_t predicted;
    item.sample     = s;
    item.tile_start = ts;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // look at in_ready while it is settled, ahead of the edge that takes it
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (predict_stencil_step(item, predicted)) expected_cells.push_back(predicted);
  endtask

  // rows of random samples, magnitude picked per row; optional stray tile starts
  task automatic send_tile_rows(input int rows, input int extra, input bit fresh,
                                input int start_odds);
    int   shift;
    logic ts;
    for (int n = 0; n < rows * GRID_N + extra; n++) begin
      if (n % GRID_N == 0) shift = $urandom_range(0, 24);
      ts = (n == 0 && fresh) || (start_odds != 0 && $urandom_range(1, start_odds) == 1);
      send_sample(rand_sample(shift), ts);
    end
  endtask

  // drop valid, drain all results, then let the chain empty out
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic program_weights(input weights_t w);
    for (int i = 0; i < 2 ** CFG_IDX_W; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      case (cfg_reg_t'(i))
        CFG_WEIGHT_UP:     cfg_wdata <= w.up;
        CFG_WEIGHT_LEFT:   cfg_wdata <= w.left;
        CFG_WEIGHT_CENTRE: cfg_wdata <= w.centre;
        CFG_WEIGHT_RIGHT:  cfg_wdata <= w.right;
        CFG_WEIGHT_DOWN:   cfg_wdata <= w.down;
        default:           cfg_wdata <= CFG_DATA_W'($urandom);  // must be ignored
      endcase
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    model_weights = w;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_extremes();
    send_sample(SAT_MAX, 1'b1);
    send_sample(SAT_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b0);
    // back-to-back tile starts, then a restart in the middle of a row
    send_sample(SAT_MIN, 1'b1);
    send_sample(SAT_MAX, 1'b1);
    send_sample(SAT_MAX, 1'b0);
    send_sample(SAT_MIN, 1'b0);
    send_sample(SAT_MAX, 1'b0);
    send_sample('0, 1'b1);
    send_sample(SAT_MIN, 1'b0);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(-32'sh0001_0000, 1'b0);
  endtask

  // reset weights over a whole tile, then overrun into the next without a start
  task automatic test_full_tile_and_overrun();
    send_tile_rows(GRID_N, 0, 1'b1, 0);
    send_tile_rows(RESULT_ROWS, $urandom_range(0, GRID_N - 1), 1'b0, 0);
  endtask

  task automatic test_weight_extremes();
    weights_t sets [5];
    sets[0] = '{up: W_MAX, left: W_MAX, centre: W_MAX, right: W_MAX, down: W_MAX};
    sets[1] = '{up: W_MIN, left: W_MIN, centre: W_MIN, right: W_MIN, down: W_MIN};
    sets[2] = '{up: W_MAX, left: W_MIN, centre: W_ZERO, right: W_MIN, down: W_MAX};
    sets[3] = '{up: W_ZERO, left: W_ZERO, centre: W_ONE, right: W_ZERO, down: W_ZERO};
    sets[4] = '{up: W_MIN, left: W_MAX, centre: W_MIN, right: W_MAX, down: W_ZERO};
    for (int k = 0; k < 5; k++) begin
      settle_pipeline();
      idle_on <= (k % 2 == 0);
      program_weights(sets[k]);
      send_tile_rows(RESULT_ROWS, $urandom_range(0, GRID_N - 1), 1'b1, 0);
    end
  endtask

  task automatic test_mid_tile_restart();
    settle_pipeline();
    idle_on <= 1'b1;
    program_weights(random_weights(1'b1));
    send_tile_rows(2 * PASSES, 60, 1'b1, 0);
    // hold the sender until every pending cell is out, then resume the same tile
    settle_pipeline();
    send_tile_rows(1, 0, 1'b0, 0);
    send_tile_rows(RESULT_ROWS - 1, 37, 1'b1, 0);
  endtask

  task automatic test_random_tiles();
    for (int k = 0; k < 5; k++) begin
      settle_pipeline();
      if (k == 4) idle_on <= 1'b0;
      program_weights(random_weights(k % 2 == 1));
      send_tile_rows(0, $urandom_range(20, 300), $urandom_range(0, 1), 16);
      send_tile_rows(2 * PASSES + 1 + $urandom_range(0, 1), $urandom_range(0, GRID_N - 1),
                     1'b1, 0);
    end
  endtask

  initial begin
    foreach (stage_lines[k]) stage_lines[k] = '0;
    next_row = 0;
    next_col = 0;
    model_weights = '{up: WEIGHT_RESET, left: WEIGHT_RESET, centre: WEIGHT_RESET,
                      right: WEIGHT_RESET, down: WEIGHT_RESET};
    repeat (7) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on <= 1'b1;

    test_directed_extremes();
    test_full_tile_and_overrun();
    test_weight_extremes();
    test_mid_tile_restart();
    test_random_tiles();
    settle_pipeline();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
